>>> hdl/mbal_pkg.sv
// Shared widths, channel codes and register indexes for the block averager.
package mbal_pkg;

  localparam int RawW     = 10;
  localparam int MvW      = 13;
  localparam int SumW     = 16;
  localparam int PhaseW   = 3;
  localparam int NumCh    = 5;
  localparam int ScaleShift = 10;
  localparam int RegIdxW  = 3;
  localparam int AddrW    = RegIdxW + 2;
  localparam int DataW    = 32;

  localparam logic [PhaseW-1:0] CH_VOLTAGE = 3'd0;
  localparam logic [PhaseW-1:0] CH_CURRENT = 3'd1;
  localparam logic [PhaseW-1:0] CH_TEMP_A  = 3'd2;
  localparam logic [PhaseW-1:0] CH_TEMP_B  = 3'd3;
  localparam logic [PhaseW-1:0] CH_TEMP_C  = 3'd4;
  localparam logic [PhaseW-1:0] CH_DISCARD = 3'd5;

  localparam logic [MvW-1:0] VREF_RESET  = 13'd5000;
  localparam logic [MvW-1:0] LIMIT_RESET = 13'd5500;

  typedef enum logic [RegIdxW-1:0] {
    REG_VREF    = 3'd0,
    REG_LIM_V   = 3'd1,
    REG_LIM_I   = 3'd2,
    REG_LIM_TA  = 3'd3,
    REG_LIM_TB  = 3'd4,
    REG_LIM_TC  = 3'd5
  } reg_idx_e;

endpackage

>>> hdl/mbal_divn.sv
// Division of a channel sum by a fixed block length through a reciprocal multiply.
module mbal_divn
  import mbal_pkg::*;
#(
  parameter int Divisor = 10
) (
  input  logic [SumW-1:0] sum_i,
  output logic [MvW-1:0]  quot_o
);

  // A shift of the sum width plus four keeps the quotient exact for divisors up to 15.
  localparam int RecipShift = SumW + 4;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
      RecipW'(((64'd1 << RecipShift) + 64'(Divisor) - 64'd1) / 64'(Divisor));

  logic [ProdW-1:0] prod;

  assign prod   = ProdW'(sum_i) * ProdW'(Recip);
  assign quot_o = prod[RecipShift +: MvW];

endmodule

>>> hdl/multichannel_block_average_limit.sv
// Top level of the five-channel block averager with per-channel trip limits.
// An item is held in the input register; its result is loaded into the result register
// once that register is empty or its current result is being taken.
// Throughput: one item per cycle while the output is not stalled; scaling, limit check,
// accumulation and the five reciprocal divides each sit in the single stage between the input and result registers.
// Reset: asynchronous, active low; clears phase, count, sums and averages and loads
// the register defaults (reference 5000 mV, all limits 5500 mV).
module multichannel_block_average_limit
  import mbal_pkg::*;
#(
  parameter int SAMPLES_PER_CHANNEL = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [RawW-1:0]    raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PhaseW-1:0]  channel_o,
  output logic [MvW-1:0]     sample_mv_o,
  output logic               over_limit_o,
  output logic [PhaseW-1:0]  next_channel_o,
  output logic               averages_valid_o,
  output logic [MvW-1:0]     avg_voltage_mv_o,
  output logic [MvW-1:0]     avg_current_mv_o,
  output logic [MvW-1:0]     avg_temp_a_mv_o,
  output logic [MvW-1:0]     avg_temp_b_mv_o,
  output logic [MvW-1:0]     avg_temp_c_mv_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  localparam int CntW  = $clog2(SAMPLES_PER_CHANNEL + 1);
  localparam int ProdW = RawW + MvW;

  logic [MvW-1:0]    vref_q;
  logic [MvW-1:0]    lim_q [NumCh];
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SumW-1:0]   sums_q [NumCh];
  logic [SumW-1:0]   sums_d [NumCh];
  logic [MvW-1:0]    pub_q [NumCh];
  logic [MvW-1:0]    pub_d [NumCh];
  logic [MvW-1:0]    quot [NumCh];

  logic              s1_valid_q;
  logic [RawW-1:0]   s1_raw_q;
  logic              in_accept;
  logic              advance;

  logic [ProdW-1:0]  prod;
  logic [MvW-1:0]    mv;
  logic [MvW-1:0]    lim_sel;
  logic [SumW-1:0]   sum_sel;
  logic [SumW:0]     sum_add;
  logic [CntW-1:0]   cnt_inc;
  logic [PhaseW-1:0] res_ch, res_next;
  logic              res_over, res_avg;

  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_VREF:   prdata = DataW'(vref_q);
      REG_LIM_V:  prdata = DataW'(lim_q[0]);
      REG_LIM_I:  prdata = DataW'(lim_q[1]);
      REG_LIM_TA: prdata = DataW'(lim_q[2]);
      REG_LIM_TB: prdata = DataW'(lim_q[3]);
      REG_LIM_TC: prdata = DataW'(lim_q[4]);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q <= VREF_RESET;
      for (int i = 0; i < NumCh; i++) begin
        lim_q[i] <= LIMIT_RESET;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VREF:   vref_q   <= pwdata[MvW-1:0];
        REG_LIM_V:  lim_q[0] <= pwdata[MvW-1:0];
        REG_LIM_I:  lim_q[1] <= pwdata[MvW-1:0];
        REG_LIM_TA: lim_q[2] <= pwdata[MvW-1:0];
        REG_LIM_TB: lim_q[3] <= pwdata[MvW-1:0];
        REG_LIM_TC: lim_q[4] <= pwdata[MvW-1:0];
        default: ;
      endcase
    end
  end

  // Input register and flow control.
  assign advance    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_raw_q <= raw_sample_i;
    end
  end

  // Scaling and per-channel selection.
  assign prod = ProdW'(s1_raw_q) * ProdW'(vref_q);
  assign mv   = prod[ScaleShift +: MvW];

  always_comb begin
    lim_sel = '0;
    sum_sel = '0;
    unique case (phase_q)
      CH_VOLTAGE: begin lim_sel = lim_q[0]; sum_sel = sums_q[0]; end
      CH_CURRENT: begin lim_sel = lim_q[1]; sum_sel = sums_q[1]; end
      CH_TEMP_A:  begin lim_sel = lim_q[2]; sum_sel = sums_q[2]; end
      CH_TEMP_B:  begin lim_sel = lim_q[3]; sum_sel = sums_q[3]; end
      CH_TEMP_C:  begin lim_sel = lim_q[4]; sum_sel = sums_q[4]; end
      default:    begin lim_sel = '0;       sum_sel = '0;        end
    endcase
  end

  assign sum_add = {1'b0, sum_sel} + (SumW + 1)'(mv);
  assign cnt_inc = cnt_q + CntW'(1);

  for (genvar c = 0; c < NumCh; c++) begin : g_div
    mbal_divn #(
      .Divisor(SAMPLES_PER_CHANNEL)
    ) u_divn (
      .sum_i  (sums_q[c]),
      .quot_o (quot[c])
    );
  end

  // Next-state and result logic.
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    sums_d   = sums_q;
    pub_d    = pub_q;
    res_ch   = phase_q;
    res_over = 1'b0;
    res_avg  = 1'b0;
    res_next = CH_VOLTAGE;
    if (phase_q >= CH_DISCARD) begin
      res_ch  = CH_DISCARD;
      res_avg = 1'b1;
      pub_d   = quot;
      phase_d = CH_VOLTAGE;
      cnt_d   = '0;
      for (int i = 0; i < NumCh; i++) begin
        sums_d[i] = '0;
      end
    end else if (mv >= lim_sel) begin
      res_over = 1'b1;
      phase_d  = CH_VOLTAGE;
      cnt_d    = '0;
      for (int i = 0; i < NumCh; i++) begin
        sums_d[i] = '0;
      end
    end else begin
      for (int i = 0; i < NumCh; i++) begin
        if (phase_q == PhaseW'(i)) begin
          sums_d[i] = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
        end
      end
      if (cnt_inc >= CntW'(SAMPLES_PER_CHANNEL)) begin
        cnt_d   = '0;
        phase_d = phase_q + PhaseW'(1);
      end else begin
        cnt_d = cnt_inc;
      end
      res_next = (phase_d >= CH_DISCARD) ? CH_VOLTAGE : phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= CH_VOLTAGE;
      cnt_q   <= '0;
      for (int i = 0; i < NumCh; i++) begin
        sums_q[i] <= '0;
        pub_q[i]  <= '0;
      end
      out_valid_o <= 1'b0;
    end else begin
      if (advance) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        sums_q  <= sums_d;
        pub_q   <= pub_d;
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      channel_o        <= res_ch;
      sample_mv_o      <= mv;
      over_limit_o     <= res_over;
      next_channel_o   <= res_next;
      averages_valid_o <= res_avg;
    end
  end

  // The averages change only when a new result is loaded, so they sit with it.
  assign avg_voltage_mv_o = pub_q[0];
  assign avg_current_mv_o = pub_q[1];
  assign avg_temp_a_mv_o  = pub_q[2];
  assign avg_temp_b_mv_o  = pub_q[3];
  assign avg_temp_c_mv_o  = pub_q[4];

endmodule

>>> tb/multichannel_block_average_limit_tb.sv
// Self-checking testbench for the five-channel block averager with trip limits.
module multichannel_block_average_limit_tb;
  import mbal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SamplesPerCh = 10;
  localparam int CycleLen     = NumCh * SamplesPerCh;
  localparam logic [RegIdxW-1:0] REG_SPARE_0 = 3'd6;
  localparam logic [RegIdxW-1:0] REG_SPARE_1 = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  typedef struct packed {
    logic [PhaseW-1:0]          channel;
    logic [MvW-1:0]             sample_mv;
    logic                       over_limit;
    logic [PhaseW-1:0]          next_channel;
    logic                       averages_valid;
    logic [NumCh-1:0][MvW-1:0]  avg_mv;
  } reading_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [RawW-1:0]   raw_sample_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [PhaseW-1:0] channel_o;
  logic [MvW-1:0]    sample_mv_o;
  logic              over_limit_o;
  logic [PhaseW-1:0] next_channel_o;
  logic              averages_valid_o;
  logic [MvW-1:0]    avg_voltage_mv_o;
  logic [MvW-1:0]    avg_current_mv_o;
  logic [MvW-1:0]    avg_temp_a_mv_o;
  logic [MvW-1:0]    avg_temp_b_mv_o;
  logic [MvW-1:0]    avg_temp_c_mv_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  multichannel_block_average_limit #(
    .SAMPLES_PER_CHANNEL(SamplesPerCh)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_sample_i    (raw_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_o       (channel_o),
    .sample_mv_o     (sample_mv_o),
    .over_limit_o    (over_limit_o),
    .next_channel_o  (next_channel_o),
    .averages_valid_o(averages_valid_o),
    .avg_voltage_mv_o(avg_voltage_mv_o),
    .avg_current_mv_o(avg_current_mv_o),
    .avg_temp_a_mv_o (avg_temp_a_mv_o),
    .avg_temp_b_mv_o (avg_temp_b_mv_o),
    .avg_temp_c_mv_o (avg_temp_c_mv_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  logic [MvW-1:0]            vref_mv;
  logic [MvW-1:0]            limit_mv [NumCh];
  logic [PhaseW-1:0]         acc_phase;
  int                        acc_count;
  logic [SumW-1:0]           channel_sum [NumCh];
  logic [NumCh-1:0][MvW-1:0] published_mv;

  logic [RawW-1:0] raw_backlog [$];
  reading_t        expected_readings [$];
  int              plan_pos;
  int unsigned     mismatches;

  int              burst_left;
  int              gap_left;
  stall_mode_e     stall_mode;
  int              stall_mode_left;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [MvW-1:0] to_millivolts(input logic [RawW-1:0] raw);
    logic [RawW+MvW-1:0] product;
    product = raw * vref_mv;
    return product[RawW+MvW-1:ScaleShift];
  endfunction

  function automatic int highest_safe_raw(input logic [MvW-1:0] lim);
    int bound;
    if (lim == 0) begin
      return -1;
    end
    if (vref_mv == 0) begin
      return 1023;
    end
    bound = (int'(lim) * 1024 - 1) / int'(vref_mv);
    return (bound > 1023) ? 1023 : bound;
  endfunction

  task automatic clear_collection();
    for (int i = 0; i < NumCh; i++) begin
      channel_sum[i] = '0;
    end
    acc_count = 0;
    acc_phase = CH_VOLTAGE;
  endtask

  task automatic take_sample(input logic [RawW-1:0] raw);
    reading_t        r;
    logic [MvW-1:0]  mv;
    logic [SumW:0]   total;
    mv = to_millivolts(raw);
    r = '0;
    r.sample_mv = mv;
    if (acc_phase == CH_DISCARD) begin
      for (int i = 0; i < NumCh; i++) begin
        published_mv[i] = MvW'(channel_sum[i] / SamplesPerCh);
      end
      r.channel = CH_DISCARD;
      r.averages_valid = 1'b1;
      r.next_channel = CH_VOLTAGE;
      clear_collection();
    end else if (mv >= limit_mv[acc_phase]) begin
      r.channel = acc_phase;
      r.over_limit = 1'b1;
      r.next_channel = CH_VOLTAGE;
      clear_collection();
    end else begin
      r.channel = acc_phase;
      total = channel_sum[acc_phase] + mv;
      channel_sum[acc_phase] = total[SumW] ? '1 : total[SumW-1:0];
      acc_count++;
      if (acc_count >= SamplesPerCh) begin
        acc_count = 0;
        acc_phase = acc_phase + 1'b1;
      end
      r.next_channel = (acc_phase == CH_DISCARD) ? CH_VOLTAGE : acc_phase;
    end
    r.avg_mv = published_mv;
    expected_readings.push_back(r);
  endtask

  // The plan position follows the block's sequence so that most samples can be
  // chosen to stay under the limit of the channel that will receive them.
  task automatic push_sample(input logic [RawW-1:0] raw);
    int ch;
    ch = plan_pos / SamplesPerCh;
    if (ch < NumCh && to_millivolts(raw) >= limit_mv[ch]) begin
      plan_pos = 0;
    end else begin
      plan_pos = (plan_pos == CycleLen) ? 0 : plan_pos + 1;
    end
    raw_backlog.push_back(raw);
  endtask

  task automatic queue_readings(input int count, input int hi_pct);
    int ch;
    int bound;
    int roll;
    for (int k = 0; k < count; k++) begin
      ch = plan_pos / SamplesPerCh;
      bound = (ch < NumCh) ? highest_safe_raw(limit_mv[ch]) : 1023;
      roll = $urandom_range(0, 99);
      if (bound < 0 || roll < 6) begin
        push_sample(RawW'($urandom_range(0, 1023)));
      end else if (roll < 10 && bound < 1023) begin
        push_sample(RawW'(bound + 1));
      end else if ($urandom_range(0, 99) < hi_pct) begin
        push_sample(RawW'($urandom_range(bound - bound / 8, bound)));
      end else begin
        push_sample(RawW'($urandom_range(0, bound)));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (raw_backlog.size() != 0 || in_valid_i || expected_readings.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [MvW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {19'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VREF:   vref_mv = val;
      REG_LIM_V:  limit_mv[CH_VOLTAGE] = val;
      REG_LIM_I:  limit_mv[CH_CURRENT] = val;
      REG_LIM_TA: limit_mv[CH_TEMP_A] = val;
      REG_LIM_TB: limit_mv[CH_TEMP_B] = val;
      REG_LIM_TC: limit_mv[CH_TEMP_C] = val;
      default: ;
    endcase
  endtask

  task automatic write_limits(input logic [MvW-1:0] v, input logic [MvW-1:0] i,
                              input logic [MvW-1:0] ta, input logic [MvW-1:0] tb,
                              input logic [MvW-1:0] tc);
    write_reg(REG_LIM_V, v);
    write_reg(REG_LIM_I, i);
    write_reg(REG_LIM_TA, ta);
    write_reg(REG_LIM_TB, tb);
    write_reg(REG_LIM_TC, tc);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (raw_backlog.size() > 0) begin
        in_valid_i   <= 1'b1;
        raw_sample_i <= raw_backlog.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(10, 60);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ~out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin : monitor
    reading_t want;
    reading_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        take_sample(raw_sample_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got.channel        = channel_o;
        got.sample_mv      = sample_mv_o;
        got.over_limit     = over_limit_o;
        got.next_channel   = next_channel_o;
        got.averages_valid = averages_valid_o;
        got.avg_mv[CH_VOLTAGE] = avg_voltage_mv_o;
        got.avg_mv[CH_CURRENT] = avg_current_mv_o;
        got.avg_mv[CH_TEMP_A]  = avg_temp_a_mv_o;
        got.avg_mv[CH_TEMP_B]  = avg_temp_b_mv_o;
        got.avg_mv[CH_TEMP_C]  = avg_temp_c_mv_o;
        if (expected_readings.size() == 0) begin
          $display("%0t: transfer with no reading expected, actual channel %0d", $time,
                   got.channel);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          check_field("channel", want.channel, got.channel);
          check_field("sample_mv", want.sample_mv, got.sample_mv);
          check_field("over_limit", want.over_limit, got.over_limit);
          check_field("next_channel", want.next_channel, got.next_channel);
          check_field("averages_valid", want.averages_valid, got.averages_valid);
          for (int i = 0; i < NumCh; i++) begin
            check_field($sformatf("avg_mv[%0d]", i), want.avg_mv[i], got.avg_mv[i]);
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    vref_mv = VREF_RESET;
    for (int i = 0; i < NumCh; i++) begin
      limit_mv[i] = LIMIT_RESET;
    end
    clear_collection();
    published_mv = '0;
    plan_pos = 0;
    mismatches = 0;
    stall_mode = STALL_NONE;
    stall_mode_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_sample(10'd0);
    push_sample(10'd1023);
    push_sample(10'h155);
    push_sample(10'h2AA);
    push_sample(10'd1);
    push_sample(10'd512);
    push_sample(10'd1022);
    push_sample(10'h3F0);
    push_sample(10'h00F);
    push_sample(10'd256);
    push_sample(10'd768);
    push_sample(10'd1023);
    wait_idle();

    write_reg(REG_LIM_V, 13'd2000);
    push_sample(10'd409);
    push_sample(10'd410);
    push_sample(10'd0);
    push_sample(10'd1023);
    push_sample(10'd409);
    queue_readings(60, 20);
    wait_idle();

    write_reg(REG_VREF, 13'd8191);
    write_limits(13'd8191, 13'd8191, 13'd8191, 13'd8191, 13'd8191);
    queue_readings(60, 90);
    wait_idle();

    write_reg(REG_VREF, 13'd0);
    write_limits(13'd1, 13'd0, 13'd5500, 13'd5500, 13'd5500);
    queue_readings(30, 0);
    wait_idle();

    write_reg(REG_VREF, 13'd5500);
    write_limits(MvW'($urandom_range(1000, 5500)), MvW'($urandom_range(1000, 5500)),
                 MvW'($urandom_range(1000, 5500)), MvW'($urandom_range(1000, 5500)),
                 MvW'($urandom_range(1000, 5500)));
    queue_readings(50, 30);
    wait_idle();
    queue_readings(50, 30);
    wait_idle();

    write_reg(REG_VREF, 13'd1);
    write_limits(13'd1, 13'd1, 13'd1, 13'd1, 13'd0);
    queue_readings(60, 50);
    wait_idle();

    write_reg(REG_SPARE_0, 13'd0);
    write_reg(REG_SPARE_1, 13'd0);
    write_reg(REG_VREF, 13'd3300);
    write_limits(13'd5500, MvW'($urandom_range(0, 5500)), MvW'($urandom_range(500, 5500)),
                 MvW'($urandom_range(500, 5500)), MvW'($urandom_range(500, 5500)));
    queue_readings(120, 40);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> multichannel_block_average_limit.f
hdl/mbal_pkg.sv
hdl/mbal_divn.sv
hdl/multichannel_block_average_limit.sv
tb/multichannel_block_average_limit_tb.sv
